FILE: hw/rtl/fbla_pkg.sv
// Shared constants, codes and types of the free block list allocator.
package fbla_pkg;

  // Field widths fixed by the item and register formats.
  localparam int ACT_W  = 2;
  localparam int BLK_W  = 10;
  localparam int CNT_W  = 11;
  localparam int STAT_W = 2;

  // Default store depth, and the limits of the list.
  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int FIRST_FREE     = 3;
  localparam int MIN_FLOOR      = 4;
  localparam int CNT_MAX        = 2047;

  // Action codes of an input item.
  localparam logic [ACT_W-1:0] ACT_FORMAT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

  // Status codes of a result item.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_SMALL = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_REL   = 2'd3;

  // Datapath step codes issued by the controller.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_NONE     = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ALLOC    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_REL      = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LINK     = 3'd3;
  localparam logic [STEP_W-1:0] STEP_FMT_INIT = 3'd4;
  localparam logic [STEP_W-1:0] STEP_FMT      = 3'd5;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              done;
    logic [STAT_W-1:0] status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic free_zero;
    logic blk_ok;
    logic fmt_ok;
    logic fmt_last;
  } dp_stat_t;

  // One result item.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  granted_block;
    logic [CNT_W-1:0]  free_left;
  } res_t;

endpackage

FILE: hw/rtl/fbla_datapath.sv
// Link memories, list head, free count and format sweep counter.
module fbla_datapath #(
  parameter int NUM_BLOCKS = fbla_pkg::NUM_BLOCKS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fbla_pkg::CNT_W-1:0] total_blocks_i,
  input  logic [fbla_pkg::CNT_W-1:0] min_blocks_i,
  input  logic [fbla_pkg::BLK_W-1:0] release_block_i,
  input  fbla_pkg::cmd_t             cmd_i,
  output fbla_pkg::dp_stat_t         stat_o,
  output fbla_pkg::res_t             res_o
);
  import fbla_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam logic [CNT_W-1:0] TotalCap = CNT_W'(NUM_BLOCKS > CNT_MAX ? CNT_MAX : NUM_BLOCKS);

  // Forward links, and back links with their valid flag in the top bit.
  logic [AW-1:0] fwd_mem  [NUM_BLOCKS];
  logic [AW:0]   back_mem [NUM_BLOCKS];

  logic [AW-1:0]    fwd_rd_q;
  logic [AW:0]      back_rd_q;
  logic [AW-1:0]    head_q, head_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [AW-1:0]    prev_q, prev_d;

  logic             fwd_we, back_we;
  logic [AW-1:0]    fwd_waddr, back_waddr;
  logic [AW-1:0]    fwd_wdata;
  logic [AW:0]      back_wdata;

  logic [CNT_W-1:0] total_eff, min_eff, free_inc;
  logic [AW-1:0]    blk_addr, idx_addr;
  logic             idx_last, idx_first;
  logic [BLK_W-1:0] granted;

  // Effective block count and minimum, with the limits applied.
  assign total_eff = (int'(total_blocks_i) > NUM_BLOCKS) ? TotalCap : total_blocks_i;
  assign min_eff   = (min_blocks_i < CNT_W'(MIN_FLOOR)) ? CNT_W'(MIN_FLOOR) : min_blocks_i;
  assign free_inc  = (free_q == '1) ? free_q : free_q + 1'b1;
  assign blk_addr  = AW'(release_block_i);
  assign idx_addr  = AW'(idx_q);
  assign idx_last  = (idx_q == total_eff - 1'b1);
  assign idx_first = (idx_q == CNT_W'(FIRST_FREE));

  // Status back to the controller.
  assign stat_o.free_zero = (free_q == '0);
  assign stat_o.blk_ok    = (release_block_i >= BLK_W'(FIRST_FREE)) &&
                            (CNT_W'(release_block_i) < total_eff);
  assign stat_o.fmt_ok    = (total_eff >= min_eff);
  assign stat_o.fmt_last  = idx_last;

  // Memory writes and register updates for the commanded step.
  always_comb begin
    fwd_we     = 1'b0;
    fwd_waddr  = idx_addr;
    fwd_wdata  = '0;
    back_we    = 1'b0;
    back_waddr = idx_addr;
    back_wdata = '0;
    head_d     = head_q;
    free_d     = free_q;
    idx_d      = idx_q;
    prev_d     = prev_q;
    granted    = '0;
    case (cmd_i.step)
      STEP_ALLOC: begin
        // Unlink the old head: its successor takes over the back link.
        fwd_we     = back_rd_q[AW];
        fwd_waddr  = back_rd_q[AW-1:0];
        fwd_wdata  = fwd_rd_q;
        back_we    = (fwd_rd_q != '0);
        back_waddr = fwd_rd_q;
        back_wdata = back_rd_q;
        head_d     = fwd_rd_q;
        free_d     = free_q - 1'b1;
        granted    = BLK_W'(head_q);
      end
      STEP_REL: begin
        // Push the released block at the head of the list.
        fwd_we     = 1'b1;
        fwd_waddr  = blk_addr;
        fwd_wdata  = (free_q == '0) ? '0 : head_q;
        back_we    = 1'b1;
        back_waddr = blk_addr;
        back_wdata = '0;
        prev_d     = head_q;
        head_d     = blk_addr;
        free_d     = free_inc;
      end
      STEP_LINK: begin
        // Point the old head back at the new one.
        back_we    = 1'b1;
        back_waddr = prev_q;
        back_wdata = {1'b1, head_q};
      end
      STEP_FMT_INIT: begin
        idx_d = CNT_W'(FIRST_FREE);
      end
      STEP_FMT: begin
        fwd_we     = 1'b1;
        fwd_wdata  = idx_last ? '0 : AW'(idx_q + 1'b1);
        back_we    = 1'b1;
        back_wdata = idx_first ? '0 : {1'b1, AW'(idx_q - 1'b1)};
        idx_d      = idx_q + 1'b1;
        if (idx_last) begin
          head_d = AW'(FIRST_FREE);
          free_d = total_eff - CNT_W'(FIRST_FREE);
        end
      end
      default: begin
      end
    endcase
  end

  // Result of the step; the count reported is the one left after it.
  assign res_o.status        = cmd_i.status;
  assign res_o.granted_block = granted;
  assign res_o.free_left     = free_d;

  // Link memories: one write each, and a registered read of the head entry.
  always_ff @(posedge clk_i) begin
    if (fwd_we) begin
      fwd_mem[fwd_waddr] <= fwd_wdata;
    end
    fwd_rd_q <= fwd_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (back_we) begin
      back_mem[back_waddr] <= back_wdata;
    end
    back_rd_q <= back_mem[head_q];
  end

  // List head and free count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      free_q <= '0;
    end else begin
      head_q <= head_d;
      free_q <= free_d;
    end
  end

  // Sweep index and saved head.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    prev_q <= prev_d;
  end

endmodule

FILE: hw/rtl/fbla_ctrl.sv
// Controller state machine that sequences each action of the allocator.
module fbla_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [fbla_pkg::ACT_W-1:0] action_i,
  input  logic                       room_i,
  input  fbla_pkg::dp_stat_t         stat_i,
  output logic                       in_ready_o,
  output fbla_pkg::cmd_t             cmd_o
);
  import fbla_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_LINK  = 2'd2;
  localparam logic [1:0] S_FMT   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE) && room_i;
  assign accept     = in_valid_i && in_ready_o;

  // Next state and datapath command.
  always_comb begin
    state_d       = state_q;
    cmd_o.step    = STEP_NONE;
    cmd_o.done    = 1'b0;
    cmd_o.status  = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_FORMAT: begin
              if (stat_i.fmt_ok) begin
                cmd_o.step = STEP_FMT_INIT;
                state_d    = S_FMT;
              end else begin
                cmd_o.done   = 1'b1;
                cmd_o.status = ST_TOO_SMALL;
              end
            end
            ACT_ALLOC: begin
              if (stat_i.free_zero) begin
                cmd_o.done   = 1'b1;
                cmd_o.status = ST_EMPTY;
              end else begin
                state_d = S_ALLOC;
              end
            end
            ACT_RELEASE: begin
              cmd_o.done = 1'b1;
              if (!stat_i.blk_ok) begin
                cmd_o.status = ST_BAD_REL;
              end else begin
                cmd_o.step = STEP_REL;
                if (!stat_i.free_zero) begin
                  state_d = S_LINK;
                end
              end
            end
            default: begin
              cmd_o.done = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        cmd_o.step = STEP_ALLOC;
        cmd_o.done = 1'b1;
        state_d    = S_IDLE;
      end
      S_LINK: begin
        cmd_o.step = STEP_LINK;
        state_d    = S_IDLE;
      end
      S_FMT: begin
        cmd_o.step = STEP_FMT;
        if (stat_i.fmt_last) begin
          cmd_o.done = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/fbla_out_buf.sv
// Two-entry result buffer: an output register with a skid stage behind it.
module fbla_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fbla_pkg::res_t push_data_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fbla_pkg::res_t out_data_o
);
  import fbla_pkg::*;

  logic out_valid_q, out_valid_d;
  logic hold_valid_q, hold_valid_d;
  res_t out_q, out_d;
  res_t hold_q, hold_d;
  logic out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign room_o      = !hold_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Keep results in order: the skid entry always moves out first.
  always_comb begin
    out_valid_d  = out_valid_q;
    hold_valid_d = hold_valid_q;
    out_d        = out_q;
    hold_d       = hold_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (hold_valid_q) begin
      if (out_free) begin
        out_d        = hold_q;
        out_valid_d  = 1'b1;
        hold_valid_d = push_i;
        hold_d       = push_data_i;
      end
    end else if (push_i) begin
      if (out_free) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        hold_d       = push_data_i;
        hold_valid_d = 1'b1;
      end
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  // Result payloads.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

endmodule

FILE: hw/rtl/free_block_list_allocator_core.sv
// Top level of the free block list allocator: register port and item channels.
//
// Input transfers carry an action (format, allocate, release) and a block
// number; every accepted item gives exactly one result transfer with a status,
// the granted block and the free count left. Configuration (total_blocks at
// byte address 0, min_blocks at 4) is to be written over the APB-style port
// only while the block is idle; the block does not enforce this. pready is
// always high. Each item's steps until its result is offered:
//   allocate: a registered read of the head entry, then the link writes.
//   Release: the push of the block, and before the next item a second
//   write to the back-link memory when the list was not empty. Format: the
//   sweep writes one link entry per cycle, blocks 3 to total-1. Rejected or
//   unused actions: result pushed at acceptance. Items are handled one at a time.
// A two-entry result buffer lets an item be accepted while an earlier result
// still waits; when the receiver stalls and both entries are full, in_ready_o
// falls until the output transfer completes.
// Reset clears the list head, the free count and the registers (total 0,
// minimum 8). The link memories are not cleared: a format fills them.
module free_block_list_allocator_core #(
  parameter int NUM_BLOCKS = fbla_pkg::NUM_BLOCKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB-style configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fbla_pkg::ACT_W-1:0]  action_i,
  input  logic [fbla_pkg::BLK_W-1:0]  release_block_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fbla_pkg::STAT_W-1:0] status_o,
  output logic [fbla_pkg::BLK_W-1:0]  granted_block_o,
  output logic [fbla_pkg::CNT_W-1:0]  free_left_o
);
  import fbla_pkg::*;

  localparam logic REG_TOTAL = 1'b0;
  localparam logic REG_MIN   = 1'b1;

  logic [CNT_W-1:0] total_blocks_q;
  logic [CNT_W-1:0] min_blocks_q;
  logic             cfg_wr;
  cmd_t             cmd;
  dp_stat_t         dp_stat;
  res_t             res;
  res_t             out_res;
  logic             room;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_blocks_q <= '0;
      min_blocks_q   <= CNT_W'(8);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TOTAL: total_blocks_q <= pwdata[CNT_W-1:0];
        REG_MIN:   min_blocks_q   <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_TOTAL: prdata = 32'(total_blocks_q);
      REG_MIN:   prdata = 32'(min_blocks_q);
      default:   prdata = '0;
    endcase
  end

  fbla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .room_i     (room),
    .stat_i     (dp_stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  fbla_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .total_blocks_i  (total_blocks_q),
    .min_blocks_i    (min_blocks_q),
    .release_block_i (release_block_i),
    .cmd_i           (cmd),
    .stat_o          (dp_stat),
    .res_o           (res)
  );

  fbla_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd.done),
    .push_data_i (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign status_o        = out_res.status;
  assign granted_block_o = out_res.granted_block;
  assign free_left_o     = out_res.free_left;

  // A block is granted only by a successful allocation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (granted_block_o == '0))
    else $error("block granted with a failing status");

  // An empty list reports no free blocks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (free_left_o == '0))
    else $error("empty status with a nonzero free count");

  // A result is never pushed while the skid entry is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.done |-> room)
    else $error("result pushed into a full buffer");

endmodule

FILE: bench/free_block_list_allocator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the free block list allocator core, with its free list predictor.
module free_block_list_allocator_core_tb;
  import fbla_pkg::*;

  // Action code the block answers without doing anything.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] ADDR_TOTAL = 3'd0;
  localparam logic [2:0] ADDR_MIN   = 3'd4;

  // Cycles allowed after the last result before the block counts as idle.
  localparam int SETTLE_CYCLES    = 4;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int LIMIT_NS         = 4_000_000;

  // Mirror of the link memories and counters, with the results still owed by the block.
  class block_list_tracker;
    bit [BLK_W-1:0] fwd_link  [NUM_BLOCKS_DEF];
    bit [BLK_W-1:0] back_link [NUM_BLOCKS_DEF];
    bit             back_ok   [NUM_BLOCKS_DEF];
    int unsigned    head      = 0;
    int unsigned    free_cnt  = 0;
    int unsigned    total_reg = 0;
    int unsigned    min_reg   = 8;
    int unsigned    errors    = 0;
    res_t           awaited [$];

    function void set_reg(logic [2:0] addr, int unsigned value);
      if (addr == ADDR_TOTAL) total_reg = value & 'h7FF;
      else min_reg = value & 'h7FF;
    endfunction

    // The block count in use never exceeds the depth of the link memories.
    function int unsigned usable_blocks();
      return (total_reg > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : total_reg;
    endfunction

    // An allocation reads the head entry only when something is free.
    function bit alloc_reads_known();
      return (free_cnt == 0) || (head >= FIRST_FREE);
    endfunction

    // Works out the result of one accepted item and updates the mirrored list.
    function void apply_action(logic [ACT_W-1:0] act, logic [BLK_W-1:0] blk);
      res_t        r;
      int unsigned tot;
      int unsigned floor_min;
      int unsigned h;
      int unsigned nxt;
      int unsigned prv;
      bit          pv;
      tot = usable_blocks();
      r.status = ST_OK;
      r.granted_block = '0;
      case (act)
        ACT_FORMAT: begin
          floor_min = (min_reg < MIN_FLOOR) ? MIN_FLOOR : min_reg;
          if (tot < floor_min) begin
            r.status = ST_TOO_SMALL;
          end else begin
            for (int unsigned i = FIRST_FREE; i < tot; i++) begin
              fwd_link[i]  = (i + 1 < tot) ? BLK_W'(i + 1) : '0;
              back_link[i] = (i == FIRST_FREE) ? '0 : BLK_W'(i - 1);
              back_ok[i]   = (i != FIRST_FREE);
            end
            head = FIRST_FREE;
            free_cnt = tot - FIRST_FREE;
          end
        end
        ACT_ALLOC: begin
          if (free_cnt == 0) begin
            r.status = ST_EMPTY;
          end else begin
            h   = head;
            nxt = fwd_link[h];
            prv = back_link[h];
            pv  = back_ok[h];
            if (pv) fwd_link[prv] = BLK_W'(nxt);
            if (nxt != 0) begin
              back_link[nxt] = BLK_W'(prv);
              back_ok[nxt]   = pv;
            end
            head = nxt;
            free_cnt--;
            r.granted_block = BLK_W'(h);
          end
        end
        ACT_RELEASE: begin
          if (blk < FIRST_FREE || blk >= tot) begin
            r.status = ST_BAD_REL;
          end else begin
            // The old head's back-link flag is written last, so it wins when it is the same block.
            if (free_cnt != 0) begin
              fwd_link[blk]   = BLK_W'(head);
              back_ok[blk]    = 1'b0;
              back_link[head] = blk;
              back_ok[head]   = 1'b1;
            end else begin
              fwd_link[blk] = '0;
              back_ok[blk]  = 1'b0;
            end
            head = blk;
            if (free_cnt < CNT_MAX) free_cnt++;
          end
        end
        default: ;
      endcase
      r.free_left = CNT_W'(free_cnt);
      awaited.push_back(r);
    endfunction

    // Compares one result transfer with the oldest outstanding expectation.
    function void check_result(logic [STAT_W-1:0] st, logic [BLK_W-1:0] blk,
                               logic [CNT_W-1:0] left);
      res_t want;
      if (awaited.size() == 0) begin
        errors++;
        $error("result transfer with nothing outstanding (status %0d)", st);
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status) begin
        errors++;
        $error("field status expected %0d actual %0d", want.status, st);
      end
      if (blk !== want.granted_block) begin
        errors++;
        $error("field granted_block expected %0d actual %0d", want.granted_block, blk);
      end
      if (left !== want.free_left) begin
        errors++;
        $error("field free_left expected %0d actual %0d", want.free_left, left);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ACT_W-1:0]  action_i = '0;
  logic [BLK_W-1:0]  release_block_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [BLK_W-1:0]  granted_block_o;
  logic [CNT_W-1:0]  free_left_o;

  int unsigned       hold_requests = 0;
  bit                no_idle = 1'b0;
  block_list_tracker sb = new();

  free_block_list_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .release_block_i (release_block_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .granted_block_o (granted_block_o),
    .free_left_o     (free_left_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One register write: a setup phase, then an access phase.
  task automatic apb_write(input logic [2:0] addr, input int unsigned value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(addr, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reads a register back and compares it with the value written.
  task automatic apb_check(input logic [2:0] addr, input int unsigned expected);
    @(posedge clk_i);
    paddr <= addr;
    @(posedge clk_i);
    if (prdata !== expected) begin
      sb.errors++;
      $error("field prdata expected %0d actual %0d", expected, prdata);
    end
  endtask

  // Waits until every expected result has been taken, then lets the block settle.
  task automatic wait_drained();
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Configuration is only written while nothing is in flight.
  task automatic configure(input int unsigned total, input int unsigned minimum);
    wait_drained();
    apb_write(ADDR_TOTAL, total);
    apb_write(ADDR_MIN, minimum);
    apb_check(ADDR_TOTAL, total & 'h7FF);
    apb_check(ADDR_MIN, minimum & 'h7FF);
  endtask

  // Offers one input transfer and holds it until it is accepted.
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [BLK_W-1:0] blk);
    in_valid_i      <= 1'b1;
    action_i        <= act;
    release_block_i <= blk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.apply_action(act, blk);
  endtask

  // Drops the input valid and idles for a number of cycles.
  task automatic pause_input(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_one(input logic [ACT_W-1:0] act, input logic [BLK_W-1:0] blk);
    send_item(act, blk);
    pause_input(1);
  endtask

  // Random mix of actions; allocation at a reserved head becomes a release or an unused code.
  task automatic send_random(input int unsigned count, input int unsigned fmt_weight);
    logic [ACT_W-1:0] act;
    logic [BLK_W-1:0] blk;
    int unsigned      roll;
    int unsigned      tot;
    for (int unsigned n = 0; n < count; n++) begin
      tot  = sb.usable_blocks();
      roll = $urandom_range(0, 99);
      if (roll < fmt_weight) act = ACT_FORMAT;
      else if (roll < 50) act = ACT_ALLOC;
      else if (roll < 95) act = ACT_RELEASE;
      else act = ACT_UNUSED;
      blk = BLK_W'($urandom_range(0, 1023));
      if (tot > FIRST_FREE && $urandom_range(0, 9) != 0)
        blk = BLK_W'($urandom_range(FIRST_FREE, tot - 1));
      if (act == ACT_RELEASE && $urandom_range(0, 19) == 0)
        blk = BLK_W'(sb.head);
      if (act == ACT_ALLOC && !sb.alloc_reads_known()) begin
        if (tot > FIRST_FREE) begin
          act = ACT_RELEASE;
          blk = BLK_W'($urandom_range(FIRST_FREE, tot - 1));
        end else begin
          act = ACT_UNUSED;
        end
      end
      send_item(act, blk);
      if (!no_idle && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 11));
    end
    pause_input(1);
  endtask

  // Receiver: random ready bursts, long holds on request, always ready at the end.
  initial begin
    int unsigned holds_served;
    holds_served = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_requests != holds_served) begin
        holds_served++;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(status_o, granted_block_o, free_left_o);
    end
  end

  // Main sequence.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Nothing is free and the store is empty before the first format.
    send_one(ACT_ALLOC, '0);
    send_one(ACT_RELEASE, BLK_W'(5));
    send_one(ACT_FORMAT, '0);
    send_one(ACT_UNUSED, '0);

    configure(20, 8);
    send_one(ACT_FORMAT, '0);
    send_random(250, 4);

    // A minimum below four acts as four.
    configure(5, 2);
    send_one(ACT_FORMAT, '0);
    send_random(40, 5);

    // Stores too small to format.
    configure(3, 8);
    send_one(ACT_FORMAT, '0);
    send_one(ACT_RELEASE, BLK_W'(3));
    configure(9, 10);
    send_one(ACT_FORMAT, '0);

    // A total above the depth is limited to the depth.
    configure(2000, 8);
    send_one(ACT_FORMAT, '0);
    send_random(150, 1);

    // The receiver holds off while items keep coming, so the input stalls.
    hold_requests++;
    send_random(30, 0);

    configure(64, 4);
    send_one(ACT_FORMAT, '0);
    send_random(150, 3);

    // Last part of the run without idling on either side.
    no_idle = 1'b1;
    send_random(170, 3);

    wait_drained();
    if (sb.errors == 0 && sb.awaited.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Run limit.
  initial begin
    #(LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule
